/* rtl/kmsi_pkg.sv */
// Package with the opcodes, status codes and state codes of the k-mer seed index.
`timescale 1ns / 1ps
`default_nettype none
package kmsi_pkg;

  // Input opcodes.
  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_RESTART = 3'd1;
  localparam logic [2:0] OP_BASE_A  = 3'd2;
  localparam logic [2:0] OP_BASE_B  = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  // Result status codes.
  localparam logic [3:0] ST_DONE     = 4'd0;
  localparam logic [3:0] ST_INVALID  = 4'd1;
  localparam logic [3:0] ST_INSERTED = 4'd2;
  localparam logic [3:0] ST_KEPT     = 4'd3;
  localparam logic [3:0] ST_DUP      = 4'd4;
  localparam logic [3:0] ST_NOT_IN_A = 4'd5;
  localparam logic [3:0] ST_DUP_IN_A = 4'd6;
  localparam logic [3:0] ST_OFF_BAND = 4'd7;
  localparam logic [3:0] ST_FULL     = 4'd8;
  localparam logic [3:0] ST_READ     = 4'd9;

  // Configuration register indexes.
  localparam logic [1:0] REG_MER_SIZE   = 2'd0;
  localparam logic [1:0] REG_DUP_IGNORE = 2'd1;
  localparam logic [1:0] REG_MIN_DIAG   = 2'd2;
  localparam logic [1:0] REG_MAX_DIAG   = 2'd3;

  // Field widths fixed by the interface.
  localparam int unsigned MER_BITS = 64;
  localparam int unsigned OUT_POS_BITS = 20;
  localparam int unsigned DIAG_BITS = 21;

  // Controller states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN_A = 3'd1;
  localparam logic [2:0] S_DIAG   = 3'd2;
  localparam logic [2:0] S_SCAN_B = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

endpackage
`default_nettype wire

/* rtl/kmsi_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module kmsi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/kmer_seed_index_unit.sv */
// Top level of the k-mer seed index: roller, A and B tables and their scan controller.
// Clear, restart, unused opcodes and invalid mers go from idle straight to the finish state,
// and a slot read passes through S_RD first. A base of A scans table A; a base of B scans A,
// checks the band and scans B. Scans read one table entry per cycle from their RAM.
// One item is in work at a time; the next is accepted while the result waits at the output.
// Reset empties both tables through their fill counts and clears the roller; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module kmer_seed_index_unit #(
  parameter int unsigned TABLE_DEPTH   = 256,  // power of two
  parameter int unsigned POSITION_BITS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [20:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [7:0]  base_char_i,
  input  wire logic [19:0] base_position_i,
  input  wire logic [7:0]  slot_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       status_o,
  output logic [63:0]      mer_value_o,
  output logic             hit_valid_o,
  output logic [19:0]      hit_a_pos_o,
  output logic [19:0]      hit_b_pos_o
);
  import kmsi_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned A_W = 1 + PB + MER_BITS;
  localparam int unsigned B_W = 1 + 2 * OUT_POS_BITS + MER_BITS;
  localparam logic [AW:0] FULL = (AW + 1)'(TABLE_DEPTH);

  // Configuration registers.
  logic [5:0]  mer_size_q;
  logic        dup_ignore_q;
  logic [20:0] min_diag_q, max_diag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mer_size_q   <= 6'd16;
      dup_ignore_q <= 1'b1;
      min_diag_q   <= '0;
      max_diag_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MER_SIZE:   mer_size_q   <= cfg_wdata_i[5:0];
        REG_DUP_IGNORE: dup_ignore_q <= cfg_wdata_i[0];
        REG_MIN_DIAG:   min_diag_q   <= cfg_wdata_i;
        REG_MAX_DIAG:   max_diag_q   <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Effective mer size and its key mask.
  logic [5:0]  k_eff;
  logic [63:0] k_mask;
  always_comb begin
    if (mer_size_q == 6'd0) begin
      k_eff = 6'd1;
    end else if (mer_size_q > 6'd32) begin
      k_eff = 6'd32;
    end else begin
      k_eff = mer_size_q;
    end
    k_mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {k_eff, 1'b0});
  end

  // Base decode and start position.
  logic [1:0]  code, bad;
  logic [31:0] start_w;
  always_comb begin
    code = 2'd0;
    bad  = 2'd3;
    case (base_char_i)
      8'h41: begin code = 2'd0; bad = 2'd0; end
      8'h43: begin code = 2'd1; bad = 2'd0; end
      8'h47: begin code = 2'd2; bad = 2'd0; end
      8'h54: begin code = 2'd3; bad = 2'd0; end
      default: ;
    endcase
    start_w = 32'(base_position_i) + 32'd1 - 32'(k_eff);
  end

  // Controller registers.
  logic [2:0]      state_q, state_d;
  logic [63:0]     mer_q, mer_d, inv_q, inv_d;
  logic [2:0]      op_q, op_d;
  logic [PB-1:0]   start_q, start_d, apos_q, apos_d;
  logic [AW-1:0]   slot_q, slot_d, cmp_q, cmp_d;
  logic [AW:0]     iss_q, iss_d, a_fill_q, a_fill_d, b_fill_q, b_fill_d;
  logic            pend_q, pend_d;
  logic [3:0]      res_st_q, res_st_d;
  logic            res_hv_q, res_hv_d;
  logic [19:0]     res_ha_q, res_ha_d, res_hb_q, res_hb_d;
  logic            out_valid_q, out_valid_d;
  logic [3:0]      out_st_q, out_st_d;
  logic [63:0]     out_mer_q, out_mer_d;
  logic            out_hv_q, out_hv_d;
  logic [19:0]     out_ha_q, out_ha_d, out_hb_q, out_hb_d;

  // Table RAM ports.
  logic           a_we, b_we;
  logic [AW-1:0]  a_waddr, b_waddr, a_raddr, b_raddr;
  logic [A_W-1:0] a_wdata, a_rdata;
  logic [B_W-1:0] b_wdata, b_rdata;

  kmsi_ram #(.WIDTH(A_W), .DEPTH(TABLE_DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  kmsi_ram #(.WIDTH(B_W), .DEPTH(TABLE_DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Fields of the entries read back.
  logic          a_rdup, b_rdup;
  logic [PB-1:0] a_rpos;
  logic [63:0]   a_rkey, b_rkey;
  logic [19:0]   b_rha, b_rhb;
  assign a_rdup = a_rdata[A_W-1];
  assign a_rpos = a_rdata[MER_BITS +: PB];
  assign a_rkey = a_rdata[MER_BITS-1:0];
  assign b_rdup = b_rdata[B_W-1];
  assign b_rha  = b_rdata[MER_BITS + OUT_POS_BITS +: OUT_POS_BITS];
  assign b_rhb  = b_rdata[MER_BITS +: OUT_POS_BITS];
  assign b_rkey = b_rdata[MER_BITS-1:0];

  // Scan helpers shared by both tables.
  logic        in_b;
  logic [AW:0] fill_cur;
  logic        match;
  logic        out_free;
  logic signed [32:0] diag, min_s, max_s;
  assign in_b     = (state_q == S_SCAN_B);
  assign fill_cur = in_b ? b_fill_q : a_fill_q;
  assign match    = pend_q && ((in_b ? b_rkey : a_rkey) == mer_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign diag     = $signed(33'(apos_q)) - $signed(33'(start_q));
  assign min_s    = 33'($signed(min_diag_q));
  assign max_s    = 33'($signed(max_diag_q));
  assign a_raddr  = iss_q[AW-1:0];
  assign b_raddr  = (state_q == S_IDLE) ? AW'(slot_i) : iss_q[AW-1:0];
  assign in_ready_o = (state_q == S_IDLE);

  // Controller next state.
  always_comb begin
    state_d  = state_q;
    mer_d    = mer_q;
    inv_d    = inv_q;
    op_d     = op_q;
    start_d  = start_q;
    apos_d   = apos_q;
    slot_d   = slot_q;
    cmp_d    = cmp_q;
    iss_d    = iss_q;
    a_fill_d = a_fill_q;
    b_fill_d = b_fill_q;
    pend_d   = 1'b0;
    res_st_d = res_st_q;
    res_hv_d = res_hv_q;
    res_ha_d = res_ha_q;
    res_hb_d = res_hb_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_st_d  = out_st_q;
    out_mer_d = out_mer_q;
    out_hv_d  = out_hv_q;
    out_ha_d  = out_ha_q;
    out_hb_d  = out_hb_q;
    a_we    = 1'b0;
    a_waddr = cmp_q;
    a_wdata = {1'b1, a_rpos, a_rkey};
    b_we    = 1'b0;
    b_waddr = cmp_q;
    b_wdata = {1'b1, b_rha, b_rhb, b_rkey};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = opcode_i;
          start_d  = start_w[PB-1:0];
          slot_d   = AW'(slot_i);
          res_st_d = ST_DONE;
          res_hv_d = 1'b0;
          res_ha_d = '0;
          res_hb_d = '0;
          iss_d    = '0;
          state_d  = S_FIN;
          unique case (opcode_i) inside
            OP_CLEAR: begin
              a_fill_d = '0;
              b_fill_d = '0;
              mer_d    = '0;
              inv_d    = '1;
            end
            OP_RESTART: begin
              mer_d = '0;
              inv_d = '1;
            end
            OP_BASE_A, OP_BASE_B: begin
              mer_d = ((mer_q << 2) | 64'(code)) & k_mask;
              inv_d = ((inv_q << 2) | 64'(bad)) & k_mask;
              if ((((inv_q << 2) | 64'(bad)) & k_mask) != '0) begin
                res_st_d = ST_INVALID;
              end else begin
                state_d = S_SCAN_A;
              end
            end
            OP_READ: state_d = S_RD;
            default: ;
          endcase
        end
      end

      S_SCAN_A, S_SCAN_B: begin
        if (match) begin
          if (!in_b && op_q == OP_BASE_B) begin
            // Key found in A during phase B: check uniqueness, then the band.
            if (a_rdup) begin
              res_st_d = ST_DUP_IN_A;
              state_d  = S_FIN;
            end else begin
              apos_d  = a_rpos;
              state_d = S_DIAG;
            end
          end else begin
            // Repeat of a key already in the table being filled.
            if (dup_ignore_q) begin
              a_we     = !in_b;
              b_we     = in_b;
              res_st_d = ST_DUP;
            end else begin
              res_st_d = ST_KEPT;
            end
            state_d = S_FIN;
          end
        end else if (iss_q < fill_cur) begin
          // Issue the next entry read; its key is compared next cycle.
          pend_d = 1'b1;
          cmp_d  = iss_q[AW-1:0];
          iss_d  = iss_q + 1'b1;
        end else if (!pend_q) begin
          // Key absent from the table.
          state_d = S_FIN;
          if (!in_b && op_q == OP_BASE_B) begin
            res_st_d = ST_NOT_IN_A;
          end else if (fill_cur >= FULL) begin
            res_st_d = ST_FULL;
          end else if (in_b) begin
            b_we     = 1'b1;
            b_waddr  = b_fill_q[AW-1:0];
            b_wdata  = {1'b0, 20'(apos_q), 20'(start_q), mer_q};
            b_fill_d = b_fill_q + 1'b1;
            res_st_d = ST_INSERTED;
          end else begin
            a_we     = 1'b1;
            a_waddr  = a_fill_q[AW-1:0];
            a_wdata  = {1'b0, start_q, mer_q};
            a_fill_d = a_fill_q + 1'b1;
            res_st_d = ST_INSERTED;
          end
        end
      end

      S_DIAG: begin
        iss_d = '0;
        if (diag < min_s || diag > max_s) begin
          res_st_d = ST_OFF_BAND;
          state_d  = S_FIN;
        end else begin
          state_d = S_SCAN_B;
        end
      end

      S_RD: begin
        res_st_d = ST_READ;
        if ((AW + 1)'(slot_q) < b_fill_q && !b_rdup) begin
          res_hv_d = 1'b1;
          res_ha_d = b_rha;
          res_hb_d = b_rhb;
        end
        state_d = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_mer_d   = mer_q;
          out_hv_d    = res_hv_q;
          out_ha_d    = res_ha_q;
          out_hb_d    = res_hb_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mer_q       <= '0;
      inv_q       <= '1;
      a_fill_q    <= '0;
      b_fill_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mer_q       <= mer_d;
      inv_q       <= inv_d;
      a_fill_q    <= a_fill_d;
      b_fill_q    <= b_fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    start_q   <= start_d;
    apos_q    <= apos_d;
    slot_q    <= slot_d;
    cmp_q     <= cmp_d;
    iss_q     <= iss_d;
    res_st_q  <= res_st_d;
    res_hv_q  <= res_hv_d;
    res_ha_q  <= res_ha_d;
    res_hb_q  <= res_hb_d;
    out_st_q  <= out_st_d;
    out_mer_q <= out_mer_d;
    out_hv_q  <= out_hv_d;
    out_ha_q  <= out_ha_d;
    out_hb_q  <= out_hb_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign mer_value_o = out_mer_q;
  assign hit_valid_o = out_hv_q;
  assign hit_a_pos_o = out_ha_q;
  assign hit_b_pos_o = out_hb_q;

  // Fill counts never pass the table depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_fill_q <= FULL && b_fill_q <= FULL) else $error("table fill count overflow");

  // A pending read only exists while a table is scanned.
  pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN_A || state_q == S_SCAN_B))
    else $error("pending read outside a scan");

  // Leaving the finish state always presents a result.
  fin_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> out_valid_q)
    else $error("result lost at finish");

  // Only one table is written in a cycle.
  one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(a_we && b_we)) else $error("both tables written at once");

endmodule
`default_nettype wire

/* tb/tb_kmer_seed_index_unit.sv */
// Self-checking testbench for the k-mer seed index unit, with a scoreboard class.
`timescale 1ns / 1ps
module tb_kmer_seed_index_unit;
  import kmsi_pkg::*;

  localparam int DEPTH = 256;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int QUIET_AFTER = 1700;
  localparam int ITEM_TARGET = 1950;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] mer;
    logic        hit;
    logic [19:0] a_pos;
    logic [19:0] b_pos;
  } seed_result_t;

  // Scoreboard: mirrors the tables and roller, and holds the expected results.
  class seed_scoreboard;
    logic [63:0] a_keys [DEPTH];
    logic [19:0] a_pos [DEPTH];
    bit          a_used [DEPTH];
    bit          a_dup [DEPTH];
    logic [63:0] b_keys [DEPTH];
    logic [19:0] b_apos [DEPTH];
    logic [19:0] b_bpos [DEPTH];
    bit          b_used [DEPTH];
    bit          b_dup [DEPTH];
    int          a_fill;
    int          b_fill;
    logic [63:0] mer_shift;
    logic [63:0] bad_shift;
    logic [5:0]  mer_size;
    logic        dup_ignore;
    logic signed [20:0] min_diag;
    logic signed [20:0] max_diag;
    seed_result_t expected_q[$];
    int errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        a_used[i] = 0; a_dup[i] = 0; b_used[i] = 0; b_dup[i] = 0;
      end
      a_fill = 0; b_fill = 0;
      mer_shift = '0; bad_shift = '1;
      mer_size = 6'd16; dup_ignore = 1'b1; min_diag = '0; max_diag = '0;
      errors = 0;
    endfunction

    function void clear_tables();
      for (int i = 0; i < DEPTH; i++) begin
        a_used[i] = 0; a_dup[i] = 0; b_used[i] = 0; b_dup[i] = 0;
      end
      a_fill = 0; b_fill = 0;
    endfunction

    // Shift one character into the roller; true when the whole k-mer is valid.
    function bit roll(logic [7:0] ch, logic [63:0] km);
      logic [1:0] code;
      logic [1:0] bad;
      code = 2'd0; bad = 2'd0;
      case (ch)
        "A": code = 2'd0;
        "C": code = 2'd1;
        "G": code = 2'd2;
        "T": code = 2'd3;
        default: bad = 2'd3;
      endcase
      mer_shift = {mer_shift[61:0], code} & km;
      bad_shift = {bad_shift[61:0], bad} & km;
      return bad_shift == '0;
    endfunction

    function int find_a(logic [63:0] key);
      for (int i = 0; i < a_fill; i++)
        if (a_used[i] && a_keys[i] == key) return i;
      return -1;
    endfunction

    function int find_b(logic [63:0] key);
      for (int i = 0; i < b_fill; i++)
        if (b_used[i] && b_keys[i] == key) return i;
      return -1;
    endfunction

    // Predict the result of one accepted item.
    function void note_input(logic [2:0] op, logic [7:0] ch, logic [19:0] pos,
                             logic [7:0] slot);
      seed_result_t r;
      int k;
      int idx;
      int bi;
      logic [63:0] km;
      logic [19:0] st;
      longint dg;
      r = '0;
      k = (mer_size == 0) ? 1 : ((mer_size > 32) ? 32 : int'(mer_size));
      km = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
      st = pos + 20'd1 - 20'(k);
      r.status = ST_DONE;
      case (op)
        OP_CLEAR: begin
          clear_tables();
          mer_shift = '0; bad_shift = '1;
        end
        OP_RESTART: begin
          mer_shift = '0; bad_shift = '1;
        end
        OP_BASE_A: begin
          if (!roll(ch, km)) begin
            r.status = ST_INVALID;
          end else begin
            idx = find_a(mer_shift);
            if (idx >= 0) begin
              if (dup_ignore) begin
                a_dup[idx] = 1; r.status = ST_DUP;
              end else begin
                r.status = ST_KEPT;
              end
            end else if (a_fill >= DEPTH) begin
              r.status = ST_FULL;
            end else begin
              a_keys[a_fill] = mer_shift; a_pos[a_fill] = st;
              a_used[a_fill] = 1; a_dup[a_fill] = 0;
              a_fill++;
              r.status = ST_INSERTED;
            end
          end
        end
        OP_BASE_B: begin
          if (!roll(ch, km)) begin
            r.status = ST_INVALID;
          end else begin
            idx = find_a(mer_shift);
            if (idx < 0) begin
              r.status = ST_NOT_IN_A;
            end else if (a_dup[idx]) begin
              r.status = ST_DUP_IN_A;
            end else begin
              dg = longint'(a_pos[idx]) - longint'(st);
              if (dg < longint'(min_diag) || dg > longint'(max_diag)) begin
                r.status = ST_OFF_BAND;
              end else begin
                bi = find_b(mer_shift);
                if (bi >= 0) begin
                  if (dup_ignore) begin
                    b_dup[bi] = 1; r.status = ST_DUP;
                  end else begin
                    r.status = ST_KEPT;
                  end
                end else if (b_fill >= DEPTH) begin
                  r.status = ST_FULL;
                end else begin
                  b_keys[b_fill] = mer_shift; b_apos[b_fill] = a_pos[idx];
                  b_bpos[b_fill] = st; b_used[b_fill] = 1; b_dup[b_fill] = 0;
                  b_fill++;
                  r.status = ST_INSERTED;
                end
              end
            end
          end
        end
        OP_READ: begin
          r.status = ST_READ;
          if (b_used[slot] && !b_dup[slot]) begin
            r.hit = 1'b1; r.a_pos = b_apos[slot]; r.b_pos = b_bpos[slot];
          end
        end
        default: ;
      endcase
      r.mer = mer_shift;
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
      errors++;
    endtask

    // Compare one result from the block with the oldest expectation.
    task check_result(seed_result_t got);
      seed_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", '0, got.status);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status) report_mismatch("status", want.status, got.status);
        if (got.mer !== want.mer) report_mismatch("mer_value", want.mer, got.mer);
        if (got.hit !== want.hit) report_mismatch("hit_valid", want.hit, got.hit);
        if (got.a_pos !== want.a_pos) report_mismatch("hit_a_pos", want.a_pos, got.a_pos);
        if (got.b_pos !== want.b_pos) report_mismatch("hit_b_pos", want.b_pos, got.b_pos);
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [20:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode = '0;
  logic [7:0]  base_char = '0;
  logic [19:0] base_position = '0;
  logic [7:0]  slot = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [3:0]  status_o;
  logic [63:0] mer_value_o;
  logic        hit_valid_o;
  logic [19:0] hit_a_pos_o;
  logic [19:0] hit_b_pos_o;

  seed_scoreboard sb = new();
  int  items_sent = 0;
  bit  quiet = 0;
  int  ready_stall = 0;
  logic [7:0] seq_a [1024];

  kmer_seed_index_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready_o),
    .opcode_i(opcode), .base_char_i(base_char), .base_position_i(base_position),
    .slot_i(slot),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready),
    .status_o(status_o), .mer_value_o(mer_value_o), .hit_valid_o(hit_valid_o),
    .hit_a_pos_o(hit_a_pos_o), .hit_b_pos_o(hit_b_pos_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver side: random stall bursts, none in the last part of the run.
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_stall > 0) begin
      ready_stall <= ready_stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      ready_stall <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check results first, then record the accepted item.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready)
      sb.check_result({status_o, mer_value_o, hit_valid_o, hit_a_pos_o, hit_b_pos_o});
    if (rst_ni && in_valid && in_ready_o)
      sb.note_input(opcode, base_char, base_position, slot);
  end

  // Offer one item, with an optional gap first, and wait for it to be taken.
  task send_item(logic [2:0] op, logic [7:0] ch, logic [19:0] pos, logic [7:0] sl);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    opcode <= op; base_char <= ch; base_position <= pos; slot <= sl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (items_sent >= QUIET_AFTER) quiet = 1;
  endtask

  // Drain all expected results, then let the block settle.
  task wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Write all four registers back to back; only called while idle.
  task write_config(logic [5:0] ms, logic di, logic signed [20:0] lo, logic signed [20:0] hi);
    cfg_we <= 1'b1; cfg_addr <= REG_MER_SIZE; cfg_wdata <= 21'(ms);
    @(posedge clk_i);
    cfg_addr <= REG_DUP_IGNORE; cfg_wdata <= 21'(di);
    @(posedge clk_i);
    cfg_addr <= REG_MIN_DIAG; cfg_wdata <= lo;
    @(posedge clk_i);
    cfg_addr <= REG_MAX_DIAG; cfg_wdata <= hi;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.mer_size = ms; sb.dup_ignore = di; sb.min_diag = lo; sb.max_diag = hi;
  endtask

  function logic [7:0] pick_base(int noise_pct, int alpha);
    logic [7:0] letters [4];
    letters = '{"A", "C", "G", "T"};
    if ($urandom_range(0, 99) < noise_pct) return 8'($urandom_range(0, 255));
    return letters[$urandom_range(0, alpha - 1)];
  endfunction

  // One random phase: configure, fill A, scan B from a shifted copy, read slots.
  task run_phase(bit fill_up);
    int la;
    int lb;
    int shift;
    int noise;
    int alpha;
    int sel;
    int reads;
    logic [5:0] ms;
    logic [19:0] a_base;
    logic [19:0] b_base;
    longint d;
    logic signed [20:0] lo;
    logic signed [20:0] hi;
    logic [7:0] ch;
    wait_idle();
    sel = $urandom_range(0, 9);
    case (sel)
      0: ms = 6'd0;
      1: ms = 6'd1;
      2: ms = 6'd32;
      3: ms = 6'($urandom_range(33, 63));
      4, 5, 6: ms = 6'($urandom_range(2, 6));
      default: ms = 6'($urandom_range(7, 24));
    endcase
    alpha = $urandom_range(2, 4);
    noise = $urandom_range(0, 8);
    la = $urandom_range(15, 90);
    lb = $urandom_range(15, 90);
    if (fill_up) begin
      ms = 6'd32; alpha = 4; noise = 0; la = 270; lb = 290;
    end
    shift = $urandom_range(0, 5);
    a_base = ($urandom_range(0, 3) == 0) ? 20'hFFFFF - 20'($urandom_range(0, 40))
                                         : 20'($urandom);
    b_base = 20'($urandom);
    d = longint'(a_base) + shift - longint'(b_base);
    sel = $urandom_range(0, 7);
    if (fill_up || sel == 0) begin
      lo = -21'sd1048576; hi = 21'sd1048575;
    end else if (sel == 1) begin
      lo = 21'sd1048575; hi = -21'sd1048576;
    end else if (sel == 2) begin
      lo = 21'($urandom); hi = 21'($urandom);
    end else begin
      lo = 21'(d - $urandom_range(0, 3)); hi = 21'(d + $urandom_range(0, 3));
    end
    write_config(ms, fill_up ? 1'b0 : 1'($urandom), lo, hi);
    if ($urandom_range(0, 3) == 0) send_item(OP_RESTART, 8'($urandom), 20'($urandom), 8'($urandom));
    else send_item(OP_CLEAR, 8'($urandom), 20'($urandom), 8'($urandom));
    for (int i = 0; i < la; i++) begin
      seq_a[i] = pick_base(noise, alpha);
      if ($urandom_range(0, 60) == 0)
        send_item(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 8'($urandom),
                  20'($urandom), 8'($urandom));
      send_item(OP_BASE_A, seq_a[i], a_base + 20'(i), 8'($urandom));
    end
    send_item(OP_RESTART, 8'($urandom), 20'($urandom), 8'($urandom));
    for (int i = 0; i < lb; i++) begin
      ch = seq_a[(i + shift) % la];
      if ($urandom_range(0, 99) < noise + 3) ch = pick_base(30, 4);
      send_item(OP_BASE_B, ch, b_base + 20'(i), 8'($urandom));
    end
    reads = fill_up ? DEPTH : $urandom_range(5, 25);
    for (int i = 0; i < reads; i++)
      send_item(OP_READ, 8'($urandom), 20'($urandom),
                fill_up ? 8'(i) : (($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 40))));
  endtask

  // Main sequence: reset, directed items, then random phases.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Unused opcodes, empty reads and invalid characters at reset settings.
    send_item(OP_UNUSED_LO, 8'hFF, 20'hFFFFF, 8'hFF);
    send_item(OP_UNUSED_HI, 8'h00, 20'h00000, 8'h00);
    send_item(OP_RESTART, "A", 20'd0, 8'd0);
    send_item(OP_READ, "A", 20'd0, 8'd0);
    send_item(OP_READ, "A", 20'd0, 8'hFF);
    send_item(OP_BASE_A, "a", 20'd3, 8'd0);
    send_item(OP_BASE_A, "N", 20'd4, 8'd0);
    wait_idle();
    // One-base mers: repeats, repeats of duplicates, position wrap, B outcomes.
    write_config(6'd1, 1'b1, -21'sd1048576, 21'sd1048575);
    send_item(OP_CLEAR, 8'd0, 20'd0, 8'd0);
    send_item(OP_BASE_A, "A", 20'd0, 8'd0);
    send_item(OP_BASE_A, "A", 20'd1, 8'd0);
    send_item(OP_BASE_A, "A", 20'd2, 8'd0);
    send_item(OP_BASE_A, "C", 20'hFFFFF, 8'd0);
    send_item(OP_BASE_A, "G", 20'd7, 8'd0);
    send_item(OP_BASE_B, "C", 20'd5, 8'd0);
    send_item(OP_BASE_B, "C", 20'd6, 8'd0);
    send_item(OP_BASE_B, "A", 20'd7, 8'd0);
    send_item(OP_BASE_B, "G", 20'hFFFFF, 8'd0);
    send_item(OP_BASE_B, "T", 20'd9, 8'd0);
    send_item(OP_BASE_B, 8'h00, 20'd10, 8'd0);
    send_item(OP_READ, 8'd0, 20'd0, 8'd0);
    send_item(OP_READ, 8'd0, 20'd0, 8'd1);
    send_item(OP_READ, 8'd0, 20'd0, 8'd2);
    while (items_sent < ITEM_TARGET) begin
      run_phase(items_sent > 600 && items_sent < 700);
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule
